@@ rtl/cpoly_pkg.sv @@
// Shared types and constants for the closest-point-on-curve search core.
// Used by closest_point_on_poly_curve_core; depends on nothing.
package cpoly_pkg;

    localparam int NCOEF       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int COORD_W     = 32;
    localparam int PARAM_W     = 17;
    localparam int T_W         = 33;
    localparam int TP_W        = 20;
    localparam int ACC_W       = 54;
    localparam int MUL_W       = 33;

    localparam logic [T_W-1:0]  STEP_MIN = 33'd429497;
    localparam logic [TP_W-1:0] TP_ONE   = 20'd65536;

    typedef logic signed [COORD_W-1:0] t_coef;
    typedef logic [T_W-1:0]            t_tpar;

endpackage

@@ rtl/closest_point_on_poly_curve_core.sv @@
// Closest point on a cubic 2-D polynomial curve by grid search and refinement.
// Depends on cpoly_pkg for widths, constants and types.
//
// The core takes one target point and window, runs a restoring divide for the
// grid step, then evaluates the curve once per candidate on a single shared
// 33x33 multiplier. An empty window finishes without the divide, and a step
// below 0.0001 finishes right after it.
// The input stalls while a search runs; a finished result sits in the output
// register, so the next item can start while it waits to transfer.
module closest_point_on_poly_curve_core
    import cpoly_pkg::*;
#(
    parameter int DEGREE     = 3,
    parameter int MAX_GRID   = 64,
    parameter int MAX_ROUNDS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [COORD_W-1:0]   i_point_x,
    input  logic [COORD_W-1:0]   i_point_y,
    input  logic [PARAM_W-1:0]   i_window_lo,
    input  logic [PARAM_W-1:0]   i_window_hi,
    input  logic [6:0]           i_grid_count,
    input  logic [3:0]           i_refine_rounds,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PARAM_W-1:0]   o_best_param
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_CHK, S_MX, S_MY, S_MP, S_MT,
        S_DIFF, S_SQX, S_SQY, S_SUM, S_DONE
    } t_state;

    typedef enum logic [1:0] {M_INIT, M_GRID, M_R1, M_R2} t_mode;

    t_state r_state;
    t_mode  r_mode;

    t_coef r_cx [NCOEF];
    t_coef r_cy [NCOEF];

    t_coef              r_px, r_py;
    logic [PARAM_W-1:0] r_lo, r_hi;
    logic [6:0]         r_n;
    logic [3:0]         r_rounds, r_round;
    logic [T_W-1:0]     r_q;
    logic [6:0]         r_rem;
    logic [5:0]         r_cnt;
    t_tpar              r_step, r_best, r_et, r_t2;
    logic [63:0]        r_bd, r_sx;
    logic [1:0]         r_k;
    logic [TP_W-1:0]    r_tp;
    logic signed [ACC_W-1:0] r_accx, r_accy;
    logic [31:0]        r_ax, r_ay;
    logic               r_satx, r_saty;
    logic signed [2*MUL_W-1:0] r_prod;
    logic               r_out_valid;
    logic [PARAM_W-1:0] r_out;
    logic [PARAM_W-1:0] r_res;

    logic signed [MUL_W-1:0]   n_ma, n_mb;
    logic [7:0]                n_tmp;
    logic [6:0]                n_nclamp;
    logic [3:0]                n_rclamp;
    logic [T_W-1:0]            n_hi32, n_lo32;
    logic signed [ACC_W-1:0]   n_dx, n_dy;
    logic signed [37:0]        n_fx, n_fy;
    logic [37:0]               n_absx, n_absy;
    logic [63:0]               n_sy;
    logic [64:0]               n_sum;
    logic [63:0]               n_d;
    logic                      n_better;
    t_tpar                     n_best;
    logic [63:0]               n_bd;
    logic [T_W:0]              n_tgrid;
    t_tpar                     n_rstep;
    logic [T_W:0]              n_t1w, n_lostep;
    t_tpar                     n_t1, n_t2;
    logic [PARAM_W:0]          n_midsum;
    logic                      n_last_k;

    assign n_hi32   = {r_hi, 16'b0};
    assign n_lo32   = {r_lo, 16'b0};
    assign n_last_k = (r_k == DEGREE[1:0]);
    assign n_midsum = {1'b0, r_lo} + {1'b0, r_hi};

    always_comb begin
        n_ma = '0;
        n_mb = '0;
        unique case (r_state)
            S_MX: begin
                n_ma = MUL_W'(r_cx[r_k]);
                n_mb = MUL_W'(r_tp);
            end
            S_MY: begin
                n_ma = MUL_W'(r_cy[r_k]);
                n_mb = MUL_W'(r_tp);
            end
            S_MP: begin
                n_ma = MUL_W'(r_tp);
                n_mb = MUL_W'(r_et[T_W-1:16]);
            end
            S_SQX: begin
                n_ma = {1'b0, r_ax};
                n_mb = {1'b0, r_ax};
            end
            S_SQY: begin
                n_ma = {1'b0, r_ay};
                n_mb = {1'b0, r_ay};
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    assign n_tmp = {r_rem, r_q[T_W-1]};

    always_comb begin
        n_nclamp = (i_grid_count == 7'd0) ? 7'd1 : i_grid_count;
        if (int'(n_nclamp) > MAX_GRID) begin
            n_nclamp = MAX_GRID[6:0];
        end
        n_rclamp = i_refine_rounds;
        if (int'(n_rclamp) > MAX_ROUNDS) begin
            n_rclamp = MAX_ROUNDS[3:0];
        end
    end

    assign n_dx   = {{6{r_px[31]}}, r_px, 16'b0} - r_accx;
    assign n_dy   = {{6{r_py[31]}}, r_py, 16'b0} - r_accy;
    assign n_fx   = n_dx[ACC_W-1:16];
    assign n_fy   = n_dy[ACC_W-1:16];
    assign n_absx = n_fx[37] ? 38'(-n_fx) : 38'(n_fx);
    assign n_absy = n_fy[37] ? 38'(-n_fy) : 38'(n_fy);

    assign n_sy  = r_saty ? '1 : 64'(r_prod[63:0]);
    assign n_sum = {1'b0, r_sx} + {1'b0, n_sy};
    assign n_d   = n_sum[64] ? '1 : n_sum[63:0];

    assign n_better = (n_d < r_bd);
    assign n_best   = ((r_mode == M_INIT) || n_better) ? r_et : r_best;
    assign n_bd     = ((r_mode == M_INIT) || n_better) ? n_d : r_bd;
    assign n_tgrid  = {1'b0, r_et} + {1'b0, r_step};
    assign n_rstep  = r_step >> 1;
    assign n_t1w    = {1'b0, n_best} + {1'b0, n_rstep};
    assign n_t1     = (n_t1w > {1'b0, n_hi32}) ? n_hi32 : n_t1w[T_W-1:0];
    assign n_lostep = {1'b0, n_lo32} + {1'b0, n_rstep};
    assign n_t2     = ({1'b0, n_best} >= n_lostep) ? (n_best - n_rstep) : n_lo32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_INIT;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NCOEF; i++) begin
                r_cx[i] <= '0;
                r_cy[i] <= '0;
            end
        end else begin
            r_prod <= n_ma * n_mb;

            if (i_cfg_we) begin
                if (i_cfg_index[0]) begin
                    r_cy[i_cfg_index[CFG_IDX_W-1:1]] <= t_coef'(i_cfg_data);
                end else begin
                    r_cx[i_cfg_index[CFG_IDX_W-1:1]] <= t_coef'(i_cfg_data);
                end
            end

            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_px     <= t_coef'(i_point_x);
                        r_py     <= t_coef'(i_point_y);
                        r_lo     <= i_window_lo;
                        r_hi     <= i_window_hi;
                        r_n      <= n_nclamp;
                        r_rounds <= n_rclamp;
                        r_round  <= '0;
                        r_rem    <= '0;
                        r_cnt    <= '0;
                        r_q      <= {i_window_hi - i_window_lo, 16'b0};
                        if (i_window_hi < i_window_lo) begin
                            r_res   <= PARAM_W'(({1'b0, i_window_lo}
                                       + {1'b0, i_window_hi}) >> 1);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (n_tmp >= {1'b0, r_n}) begin
                        r_rem <= 7'(n_tmp - {1'b0, r_n});
                        r_q   <= {r_q[T_W-2:0], 1'b1};
                    end else begin
                        r_rem <= n_tmp[6:0];
                        r_q   <= {r_q[T_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(T_W - 1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_q < STEP_MIN) begin
                        r_res   <= n_midsum[PARAM_W:1];
                        r_state <= S_DONE;
                    end else begin
                        r_step  <= r_q;
                        r_best  <= n_hi32;
                        r_et    <= n_hi32;
                        r_mode  <= M_INIT;
                        r_k     <= '0;
                        r_tp    <= TP_ONE;
                        r_accx  <= '0;
                        r_accy  <= '0;
                        r_state <= S_MX;
                    end
                end
                S_MX: begin
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_accx  <= r_accx + ACC_W'(r_prod);
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_accy  <= r_accy + ACC_W'(r_prod);
                    r_state <= n_last_k ? S_DIFF : S_MT;
                end
                S_MT: begin
                    r_tp    <= r_prod[TP_W+15:16];
                    r_k     <= r_k + 2'd1;
                    r_state <= S_MX;
                end
                S_DIFF: begin
                    r_ax    <= n_absx[31:0];
                    r_ay    <= n_absy[31:0];
                    r_satx  <= |n_absx[37:32];
                    r_saty  <= |n_absy[37:32];
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sx    <= r_satx ? '1 : 64'(r_prod[63:0]);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_best <= n_best;
                    r_bd   <= n_bd;
                    r_k    <= '0;
                    r_tp   <= TP_ONE;
                    r_accx <= '0;
                    r_accy <= '0;
                    r_state <= S_MX;
                    unique case (r_mode) inside
                        M_INIT: begin
                            r_et   <= n_lo32;
                            r_mode <= M_GRID;
                        end
                        M_R1: begin
                            r_et   <= r_t2;
                            r_mode <= M_R2;
                        end
                        M_GRID, M_R2: begin
                            if ((r_mode == M_GRID) && (n_tgrid <= {1'b0, n_hi32})) begin
                                r_et <= n_tgrid[T_W-1:0];
                            end else if (r_round == r_rounds) begin
                                r_res   <= n_best[T_W-1:16];
                                r_state <= S_DONE;
                            end else begin
                                r_step  <= n_rstep;
                                r_et    <= n_t1;
                                r_t2    <= n_t2;
                                r_round <= r_round + 4'd1;
                                r_mode  <= M_R1;
                            end
                        end
                        default: begin
                            r_mode <= M_INIT;
                        end
                    endcase
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_best_param = r_out;

`ifndef SYNTHESIS
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished search");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_n != 7'd0))
        else $error("grid divide with zero divisor");

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MX) |-> (int'(r_k) <= DEGREE))
        else $error("power index beyond curve degree");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_round <= r_rounds))
        else $error("refinement ran past its round count");
`endif

endmodule

@@ dv/tb_closest_point_on_poly_curve_core.sv @@
// Self-checking testbench for closest_point_on_poly_curve_core: directed and random searches
// under random idling, checked against an in-bench grid-search predictor.
// Depends on cpoly_pkg and the core RTL.
module tb_closest_point_on_poly_curve_core
    import cpoly_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [PARAM_W-1:0] lo;
        logic [PARAM_W-1:0] hi;
        logic [6:0]         grid;
        logic [3:0]         rounds;
    } t_search_req;

    localparam int GRID_CAP  = 64;
    localparam int ROUND_CAP = 15;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COORD_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [COORD_W-1:0]   i_point_x;
    logic [COORD_W-1:0]   i_point_y;
    logic [PARAM_W-1:0]   i_window_lo;
    logic [PARAM_W-1:0]   i_window_hi;
    logic [6:0]           i_grid_count;
    logic [3:0]           i_refine_rounds;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [PARAM_W-1:0]   o_best_param;

    closest_point_on_poly_curve_core i_dut (.*);

    t_search_req        pending_req[$];
    t_search_req        cur_req;
    logic [PARAM_W-1:0] best_q[$];
    longint             coef_x[NCOEF];
    longint             coef_y[NCOEF];
    int                 mismatches = 0;
    int                 send_gap = 0;
    int                 recv_gap = 0;
    int                 hold_left = 0;
    bit                 burst = 0;
    bit                 in_fire = 0;
    bit                 out_fire = 0;

    function automatic logic [63:0] sat_square(longint d);
        logic [63:0] a;
        a = (d < 0) ? -d : d;
        if (a > 64'hFFFF_FFFF) return '1;
        return a * a;
    endfunction

    function automatic logic [63:0] curve_dist(logic [31:0] px, logic [31:0] py,
                                               logic [63:0] t32);
        logic [63:0] t16, tp, sx, sy;
        logic [64:0] s;
        longint fx, fy, dx, dy;
        t16 = t32 >> 16;
        tp = 64'd65536;
        fx = 0;
        fy = 0;
        for (int k = 0; k < NCOEF; k++) begin
            fx += coef_x[k] * longint'(tp);
            fy += coef_y[k] * longint'(tp);
            tp = (tp * t16) >> 16;
        end
        dx = (longint'(signed'(px)) * 65536 - fx) >>> 16;
        dy = (longint'(signed'(py)) * 65536 - fy) >>> 16;
        sx = sat_square(dx);
        sy = sat_square(dy);
        s = {1'b0, sx} + {1'b0, sy};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [PARAM_W-1:0] predict_best(t_search_req r);
        logic [63:0] n, step, lo32, hi32, best, bd, d, t, t1, t2;
        logic [17:0] mid;
        int rounds;
        n = 64'(r.grid);
        if (n == 0) n = 64'd1;
        if (n > GRID_CAP) n = 64'(GRID_CAP);
        rounds = (r.rounds > ROUND_CAP) ? ROUND_CAP : int'(r.rounds);
        mid = ({1'b0, r.lo} + {1'b0, r.hi}) >> 1;
        if (r.hi < r.lo) return mid[PARAM_W-1:0];
        step = (64'(r.hi - r.lo) << 16) / n;
        if (step < 64'(STEP_MIN)) return mid[PARAM_W-1:0];
        lo32 = 64'(r.lo) << 16;
        hi32 = 64'(r.hi) << 16;
        best = hi32;
        bd = curve_dist(r.px, r.py, best);
        for (t = lo32; t <= hi32; t += step) begin
            d = curve_dist(r.px, r.py, t);
            if (d < bd) begin
                bd = d;
                best = t;
            end
        end
        for (int i = 0; i < rounds; i++) begin
            step >>= 1;
            t1 = (best + step > hi32) ? hi32 : best + step;
            t2 = (best >= lo32 + step) ? best - step : lo32;
            d = curve_dist(r.px, r.py, t1);
            if (d < bd) begin
                bd = d;
                best = t1;
            end
            d = curve_dist(r.px, r.py, t2);
            if (d < bd) begin
                bd = d;
                best = t2;
            end
        end
        return best[32:16];
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Transfers are sampled at the rising edge; expectations are computed on acceptance.
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        out_fire = i_rst_n && o_out_valid && !i_out_stall;
        if (in_fire) best_q = {best_q, predict_best(cur_req)};
        if (out_fire) begin
            if (best_q.size() == 0) begin
                $display("%0t: unexpected result, actual best_param %0d", $time, o_best_param);
                mismatches++;
            end else begin
                logic [PARAM_W-1:0] want;
                want = best_q.pop_front();
                if (o_best_param !== want) begin
                    $display("%0t: best_param expected %0d actual %0d",
                             $time, want, o_best_param);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
                cur_req = pending_req.pop_front();
                i_point_x <= cur_req.px;
                i_point_y <= cur_req.py;
                i_window_lo <= cur_req.lo;
                i_window_hi <= cur_req.hi;
                i_grid_count <= cur_req.grid;
                i_refine_rounds <= cur_req.rounds;
                i_in_valid <= 1'b1;
                send_gap = burst ? 0 : $urandom_range(0, 6);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) recv_gap = burst ? 0 : $urandom_range(0, 6);
            else if (recv_gap > 0) recv_gap--;
            if (hold_left > 0) hold_left--;
            i_out_stall <= (recv_gap > 0) || (hold_left > 0);
        end
    end

    function automatic logic [31:0] near_coord();
        return 32'($urandom_range(0, 524288)) - 32'd262144;
    endfunction

    function automatic t_search_req random_req();
        t_search_req r;
        int sel;
        sel = $urandom_range(0, 9);
        r.px = (sel < 2) ? $urandom() : near_coord();
        r.py = (sel < 2) ? $urandom() : near_coord();
        sel = $urandom_range(0, 9);
        r.lo = PARAM_W'($urandom_range(0, 65536));
        if (sel < 7) begin
            r.hi = PARAM_W'($urandom_range(r.lo, 65536));
        end else if (sel == 7) begin
            r.hi = PARAM_W'($urandom_range(0, 131071));
        end else if (sel == 8) begin
            r.lo = PARAM_W'($urandom_range(0, 131071));
            r.hi = PARAM_W'($urandom_range(r.lo, 131071));
        end else begin
            r.hi = PARAM_W'(r.lo + $urandom_range(0, 8));
        end
        sel = $urandom_range(0, 9);
        r.grid = (sel < 8) ? 7'($urandom_range(1, 24))
               : (sel == 8) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(25, 64));
        r.rounds = 4'($urandom_range(0, 15));
        return r;
    endfunction

    task automatic push_req(logic [31:0] px, logic [31:0] py, int lo, int hi,
                            int grid, int rounds);
        t_search_req r;
        r.px = px;
        r.py = py;
        r.lo = PARAM_W'(lo);
        r.hi = PARAM_W'(hi);
        r.grid = 7'(grid);
        r.rounds = 4'(rounds);
        pending_req = {pending_req, r};
    endtask

    task automatic drain();
        while (pending_req.size() > 0 || i_in_valid || best_q.size() > 0) @(posedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic run_random(int count, bit no_idle);
        burst = no_idle;
        repeat (count) pending_req = {pending_req, random_req()};
        drain();
    endtask

    task automatic write_coef(int idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_IDX_W'(idx);
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx % 2) coef_y[idx / 2] = longint'(signed'(value));
        else coef_x[idx / 2] = longint'(signed'(value));
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_point_x = '0;
        i_point_y = '0;
        i_window_lo = '0;
        i_window_hi = '0;
        i_grid_count = '0;
        i_refine_rounds = '0;
        i_out_stall = 0;
        for (int k = 0; k < NCOEF; k++) begin
            coef_x[k] = 0;
            coef_y[k] = 0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;

        run_random(80, 0);

        for (int i = 0; i < 2 * NCOEF; i++) write_coef(i, near_coord());
        push_req(32'h0001_0000, 32'h0000_8000, 0, 65536, 20, 5);
        push_req(32'h0000_0000, 32'h0000_0000, 0, 65536, 0, 3);
        push_req(32'hFFFF_0000, 32'h0002_0000, 0, 65536, 127, 2);
        push_req(32'h0000_4000, 32'hFFFF_C000, 0, 65536, 64, 0);
        push_req(32'h0003_0000, 32'h0001_0000, 0, 65536, 1, 15);
        push_req(32'h7FFF_FFFF, 32'h8000_0000, 0, 65536, 8, 4);
        push_req(32'h8000_0000, 32'h7FFF_FFFF, 0, 65536, 8, 4);
        push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 65536, 10, 7);
        push_req(32'h0001_0000, 32'h0001_0000, 40000, 20000, 10, 5);
        push_req(32'h0001_0000, 32'h0001_0000, 1000, 1000, 4, 5);
        push_req(32'h0001_0000, 32'h0001_0000, 1000, 1006, 1, 3);
        push_req(32'h0001_0000, 32'h0001_0000, 1000, 1007, 1, 3);
        push_req(32'h0001_0000, 32'h0001_0000, 0, 420, 64, 3);
        push_req(32'h0002_0000, 32'h0002_0000, 65536, 131071, 16, 6);
        push_req(32'h0002_0000, 32'hFFFE_0000, 0, 131071, 32, 15);
        push_req(32'h0000_0000, 32'h0000_0000, 0, 0, 5, 1);
        push_req(32'h0000_0000, 32'h0000_0000, 131071, 131071, 5, 1);
        push_req(32'h0000_0000, 32'h0000_0000, 131071, 0, 64, 15);
        push_req(32'h5555_5555, 32'hAAAA_AAAA, 12345, 54321, 13, 9);
        push_req(32'hAAAA_AAAA, 32'h5555_5555, 7, 65535, 64, 15);
        drain();
        run_random(280, 0);

        hold_left = 3000;
        run_random(100, 1);

        for (int i = 0; i < 2 * NCOEF; i++)
            write_coef(i, (i % 3 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        run_random(100, 0);

        for (int i = 0; i < 2 * NCOEF; i++) write_coef(i, $urandom());
        run_random(100, 0);

        for (int i = 0; i < 2 * NCOEF; i++) write_coef(i, near_coord());
        run_random(220, 0);

        if (mismatches == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #80ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
